@@ sv/owm_pkg.sv @@
`default_nettype none

package owm_pkg;

	localparam int unsigned REG_W     = 10;
	localparam int unsigned REG_IDX_W = 3;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_RESET = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RESET_LOW     = 3'd0,
		REG_PRESENCE_WAIT = 3'd1,
		REG_WRITE_ONE_LOW = 3'd2,
		REG_SLOT          = 3'd3,
		REG_RECOVERY      = 3'd4,
		REG_READ_LOW      = 3'd5,
		REG_READ_SAMPLE   = 3'd6,
		REG_BYTE_GAP      = 3'd7
	} reg_idx_t;

	localparam logic [REG_W-1:0] RST_RESET_LOW     = 10'd500;
	localparam logic [REG_W-1:0] RST_PRESENCE_WAIT = 10'd60;
	localparam logic [REG_W-1:0] RST_WRITE_ONE_LOW = 10'd15;
	localparam logic [REG_W-1:0] RST_SLOT          = 10'd60;
	localparam logic [REG_W-1:0] RST_RECOVERY      = 10'd1;
	localparam logic [REG_W-1:0] RST_READ_LOW      = 10'd1;
	localparam logic [REG_W-1:0] RST_READ_SAMPLE   = 10'd2;
	localparam logic [REG_W-1:0] RST_BYTE_GAP      = 10'd200;

	typedef struct packed {
		logic [REG_W-1:0] reset_low_ticks;
		logic [REG_W-1:0] presence_wait_ticks;
		logic [REG_W-1:0] write_one_low_ticks;
		logic [REG_W-1:0] slot_ticks;
		logic [REG_W-1:0] recovery_ticks;
		logic [REG_W-1:0] read_low_ticks;
		logic [REG_W-1:0] read_sample_ticks;
		logic [REG_W-1:0] byte_gap_ticks;
	} cfg_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] rx_byte;
	} res_t;

endpackage

`default_nettype wire

@@ sv/owm_if.sv @@
`default_nettype none

interface owm_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] tx_byte;
	logic       line_in;

	modport source(output valid, output opcode, output tx_byte, output line_in, input ready);
	modport sink(input valid, input opcode, input tx_byte, input line_in, output ready);
endinterface

interface owm_res_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic       presence;
	logic [7:0] rx_byte;

	modport source(output valid, output drive_low, output busy_res, output done_res,
		output presence, output rx_byte, input ready);
	modport sink(input valid, input drive_low, input busy_res, input done_res,
		input presence, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ sv/onewire_bus_master.sv @@
// 1-Wire bus master, one command word per microsecond tick.
// cmd channel: each word is one tick and carries an opcode (none, reset,
// write byte, read byte), the byte to send and the sampled bus level.
// A command is taken only while no operation runs; otherwise it is ignored.
// res channel: one word per cmd word, with drive_low for the open-drain
// pad (1 pulls low, 0 releases to the pull-up), busy, a done strobe on the
// last tick of an operation, presence after a reset pulse and the received
// byte after a read (both zero outside done).
// Timing registers are written through cfg_we/cfg_idx/cfg_data; the user must write them only while
// no operation is running, as the block itself does not enforce it.
// res valid rises in the cycle after a cmd word is accepted, from the single result register after
// the sequencer; one word per cycle is sustained while the res sink takes each word.
// A stalled res sink holds the result register; cmd.ready drops until the
// word is taken, so no tick is lost and the bus timing pauses with it.
// Reset returns the sequencer to idle, empties the result register and
// loads the default timing (500, 60, 15, 60, 1, 1, 2, 200 ticks).
`default_nettype none

module onewire_bus_master #(
	parameter int unsigned COUNT_WIDTH = 10
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	owm_cmd_if.sink                            cmd,
	owm_res_if.source                          res,
	input  wire logic                          cfg_we,
	input  wire logic [owm_pkg::REG_IDX_W-1:0] cfg_idx,
	input  wire logic [owm_pkg::REG_W-1:0]     cfg_data
);

	owm_pkg::cfg_t cfg;
	owm_pkg::res_t seq_res;
	owm_pkg::res_t res_q;
	logic          res_valid_q;
	logic          accept;

	assign cmd.ready = ~res_valid_q | res.ready;
	assign accept    = cmd.valid & cmd.ready;

	owm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_idx),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	owm_seq #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (accept),
		.opcode  (cmd.opcode),
		.tx_byte (cmd.tx_byte),
		.line_in (cmd.line_in),
		.cfg     (cfg),
		.res     (seq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= seq_res;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.drive_low = res_q.drive_low;
	assign res.busy_res  = res_q.busy_res;
	assign res.done_res  = res_q.done_res;
	assign res.presence  = res_q.presence;
	assign res.rx_byte   = res_q.rx_byte;

	a_accept_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res.valid)
		else $error("accepted word produced no result");

	a_drive_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.drive_low || res.done_res) |-> res.busy_res)
		else $error("bus driven or done outside an operation");

	a_presence_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.presence |-> res.done_res && res.rx_byte == 8'd0)
		else $error("presence outside done of a reset");

	a_rx_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.rx_byte != 8'd0 |-> res.done_res && !res.drive_low)
		else $error("received byte outside done of a read");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |-> !cmd.ready)
		else $error("command taken while result stalled");

endmodule

`default_nettype wire

@@ sv/owm_cfg_regs.sv @@
`default_nettype none

module owm_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           we,
	input  wire logic [owm_pkg::REG_IDX_W-1:0]  idx,
	input  wire logic [owm_pkg::REG_W-1:0]      data,
	output owm_pkg::cfg_t                       cfg
);

	owm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks     <= owm_pkg::RST_RESET_LOW;
			cfg_q.presence_wait_ticks <= owm_pkg::RST_PRESENCE_WAIT;
			cfg_q.write_one_low_ticks <= owm_pkg::RST_WRITE_ONE_LOW;
			cfg_q.slot_ticks          <= owm_pkg::RST_SLOT;
			cfg_q.recovery_ticks      <= owm_pkg::RST_RECOVERY;
			cfg_q.read_low_ticks      <= owm_pkg::RST_READ_LOW;
			cfg_q.read_sample_ticks   <= owm_pkg::RST_READ_SAMPLE;
			cfg_q.byte_gap_ticks      <= owm_pkg::RST_BYTE_GAP;
		end else if (we) begin
			case (owm_pkg::reg_idx_t'(idx))
				owm_pkg::REG_RESET_LOW:     cfg_q.reset_low_ticks     <= data;
				owm_pkg::REG_PRESENCE_WAIT: cfg_q.presence_wait_ticks <= data;
				owm_pkg::REG_WRITE_ONE_LOW: cfg_q.write_one_low_ticks <= data;
				owm_pkg::REG_SLOT:          cfg_q.slot_ticks          <= data;
				owm_pkg::REG_RECOVERY:      cfg_q.recovery_ticks      <= data;
				owm_pkg::REG_READ_LOW:      cfg_q.read_low_ticks      <= data;
				owm_pkg::REG_READ_SAMPLE:   cfg_q.read_sample_ticks   <= data;
				owm_pkg::REG_BYTE_GAP:      cfg_q.byte_gap_ticks      <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ sv/owm_seq.sv @@
`default_nettype none

module owm_seq #(
	parameter int unsigned COUNT_WIDTH = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [1:0]    opcode,
	input  wire logic [7:0]    tx_byte,
	input  wire logic          line_in,
	input  wire owm_pkg::cfg_t cfg,
	output owm_pkg::res_t      res
);

	localparam int unsigned RW = owm_pkg::REG_W;
	localparam int unsigned LW = ((COUNT_WIDTH > RW) ? COUNT_WIDTH : RW) + 1;
	localparam logic [LW-1:0] LEN_LIM = LW'(1) << COUNT_WIDTH;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_LOW   = 3'd1,
		PH_WAIT  = 3'd2,
		PH_REST  = 3'd3,
		PH_RECOV = 3'd4,
		PH_GAP   = 3'd5
	} phase_t;

	phase_t                 phase_q;
	logic [COUNT_WIDTH-1:0] tick_q;
	logic [2:0]             bit_q;
	logic [7:0]             sr_q;
	owm_pkg::op_t           op_q;
	logic                   pres_q;

	phase_t                 c_ph, n_ph;
	logic [COUNT_WIDTH-1:0] c_tc, n_tc;
	logic [2:0]             c_bi, n_bi;
	logic [7:0]             c_sr, n_sr;
	owm_pkg::op_t           c_op, in_op;
	logic                   c_pf, n_pf;
	logic [RW-1:0]          low_w, rest_w, rest_r, cur_len;
	logic [RW:0]            used_r;
	logic [LW-1:0]          len_x, len_c, tc_p1;
	logic                   ph_end, bit_end, fin;

	function automatic logic [RW-1:0] max1(input logic [RW-1:0] v);
		return (v == '0) ? RW'(1) : v;
	endfunction

	assign in_op = owm_pkg::op_t'(opcode);

	always_comb begin
		c_ph = phase_q;
		c_tc = tick_q;
		c_bi = bit_q;
		c_sr = sr_q;
		c_op = op_q;
		c_pf = pres_q;
		if (phase_q == PH_IDLE && in_op != owm_pkg::OP_NONE) begin
			c_op = in_op;
			c_tc = '0;
			c_bi = '0;
			c_sr = (in_op == owm_pkg::OP_WRITE) ? tx_byte : 8'd0;
			c_pf = 1'b0;
			if (in_op == owm_pkg::OP_READ && cfg.byte_gap_ticks != '0) begin
				c_ph = PH_GAP;
			end else begin
				c_ph = PH_LOW;
			end
		end

		// slot arithmetic
		low_w  = max1(c_sr[0] ? cfg.write_one_low_ticks : cfg.slot_ticks);
		rest_w = (cfg.slot_ticks > low_w) ? cfg.slot_ticks - low_w : '0;
		used_r = {1'b0, max1(cfg.read_low_ticks)} + {1'b0, max1(cfg.read_sample_ticks)};
		rest_r = ({1'b0, cfg.slot_ticks} > used_r) ? cfg.slot_ticks - used_r[RW-1:0] : '0;

		case (c_ph)
			PH_LOW: begin
				case (c_op)
					owm_pkg::OP_RESET: cur_len = max1(cfg.reset_low_ticks);
					owm_pkg::OP_WRITE: cur_len = low_w;
					default:           cur_len = max1(cfg.read_low_ticks);
				endcase
			end
			PH_WAIT: cur_len = max1((c_op == owm_pkg::OP_RESET) ?
				cfg.presence_wait_ticks : cfg.read_sample_ticks);
			PH_REST:  cur_len = (c_op == owm_pkg::OP_WRITE) ? rest_w : rest_r;
			PH_RECOV: cur_len = cfg.recovery_ticks;
			PH_GAP:   cur_len = cfg.byte_gap_ticks;
			default:  cur_len = RW'(1);
		endcase

		len_x  = LW'(cur_len);
		len_c  = (len_x > LEN_LIM) ? LEN_LIM : len_x;
		tc_p1  = LW'(c_tc) + LW'(1);
		ph_end = tc_p1 >= len_c;

		n_ph    = c_ph;
		n_tc    = c_tc;
		n_bi    = c_bi;
		n_sr    = c_sr;
		n_pf    = c_pf;
		bit_end = 1'b0;
		fin     = 1'b0;
		res     = '0;

		if (c_ph != PH_IDLE) begin
			res.busy_res  = 1'b1;
			res.drive_low = (c_ph == PH_LOW);
			if (ph_end) begin
				n_tc = '0;
				if (c_ph == PH_WAIT) begin
					if (c_op == owm_pkg::OP_RESET) begin
						n_pf = ~line_in;
					end else begin
						n_sr = {line_in, c_sr[7:1]};
					end
				end
				// leave the phase, skipping any that last no ticks
				case (c_ph)
					PH_LOW: begin
						if (c_op == owm_pkg::OP_WRITE) begin
							if (rest_w != '0) begin
								n_ph = PH_REST;
							end else if (cfg.recovery_ticks != '0) begin
								n_ph = PH_RECOV;
							end else begin
								bit_end = 1'b1;
							end
						end else begin
							n_ph = PH_WAIT;
						end
					end
					PH_WAIT: begin
						if (c_op != owm_pkg::OP_READ) begin
							fin = 1'b1;
						end else if (rest_r != '0) begin
							n_ph = PH_REST;
						end else begin
							bit_end = 1'b1;
						end
					end
					PH_REST: begin
						if (c_op == owm_pkg::OP_WRITE && cfg.recovery_ticks != '0) begin
							n_ph = PH_RECOV;
						end else begin
							bit_end = 1'b1;
						end
					end
					PH_RECOV: bit_end = 1'b1;
					PH_GAP:   n_ph = PH_LOW;
					default:  fin = 1'b1;
				endcase
				if (bit_end) begin
					if (c_op == owm_pkg::OP_WRITE) begin
						n_sr = {1'b0, n_sr[7:1]};
					end
					if (c_bi == 3'd7) begin
						fin = 1'b1;
					end else begin
						n_bi = c_bi + 3'd1;
						n_ph = PH_LOW;
					end
				end
				if (fin) begin
					res.done_res = 1'b1;
					res.presence = (c_op == owm_pkg::OP_RESET) ? n_pf : 1'b0;
					res.rx_byte  = (c_op == owm_pkg::OP_READ) ? n_sr : 8'd0;
					n_ph         = PH_IDLE;
				end
			end else begin
				n_tc = c_tc + COUNT_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			sr_q    <= '0;
			op_q    <= owm_pkg::OP_NONE;
			pres_q  <= 1'b0;
		end else if (step) begin
			phase_q <= n_ph;
			tick_q  <= n_tc;
			bit_q   <= n_bi;
			sr_q    <= n_sr;
			op_q    <= c_op;
			pres_q  <= n_pf;
		end
	end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import owm_pkg::*;

	localparam int unsigned SEQ_CW    = 10;
	localparam int unsigned MAX_CYCLE = 200000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOW,
		ST_WAIT,
		ST_REST,
		ST_RECOV,
		ST_GAP
	} seq_state_t;

	typedef enum int {
		LINE_LOW,
		LINE_HIGH,
		LINE_RAND
	} line_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_idx;
	logic [REG_W-1:0]     cfg_data;

	owm_cmd_if cmd_if();
	owm_res_if res_if();

	onewire_bus_master #(
		.COUNT_WIDTH(SEQ_CW)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_if),
		.res     (res_if),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data)
	);

	// bus master model
	seq_state_t  seq_st;
	int unsigned seq_ticks;
	logic [2:0]  seq_bit;
	logic [7:0]  seq_shift;
	op_t         seq_op;
	logic        seq_pres;
	int unsigned timing [8];

	res_t        tick_outputs [$];
	int unsigned n_bad;
	int unsigned src_idle;
	int unsigned sink_stall;
	int unsigned drain_per_mille;
	int unsigned cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < MAX_CYCLE) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	function automatic void init_model();
		seq_st    = ST_IDLE;
		seq_ticks = 0;
		seq_bit   = 3'd0;
		seq_shift = 8'd0;
		seq_op    = OP_NONE;
		seq_pres  = 1'b0;
		timing[REG_RESET_LOW]     = RST_RESET_LOW;
		timing[REG_PRESENCE_WAIT] = RST_PRESENCE_WAIT;
		timing[REG_WRITE_ONE_LOW] = RST_WRITE_ONE_LOW;
		timing[REG_SLOT]          = RST_SLOT;
		timing[REG_RECOVERY]      = RST_RECOVERY;
		timing[REG_READ_LOW]      = RST_READ_LOW;
		timing[REG_READ_SAMPLE]   = RST_READ_SAMPLE;
		timing[REG_BYTE_GAP]      = RST_BYTE_GAP;
	endfunction

	function automatic int unsigned clamp_len(int unsigned v);
		int unsigned lim;
		lim = 32'd1 << SEQ_CW;
		return (v > lim) ? lim : v;
	endfunction

	function automatic int unsigned min1(int unsigned v);
		return (v == 0) ? 1 : v;
	endfunction

	function automatic int unsigned low_len();
		if (seq_op == OP_RESET)
			return min1(timing[REG_RESET_LOW]);
		if (seq_op == OP_WRITE)
			return min1(seq_shift[0] ? timing[REG_WRITE_ONE_LOW] : timing[REG_SLOT]);
		return min1(timing[REG_READ_LOW]);
	endfunction

	function automatic int unsigned seg_len(seq_state_t st);
		int unsigned used;
		case (st)
			ST_LOW: return clamp_len(low_len());
			ST_WAIT: return clamp_len(min1(seq_op == OP_RESET ? timing[REG_PRESENCE_WAIT]
				: timing[REG_READ_SAMPLE]));
			ST_REST: begin
				if (seq_op == OP_WRITE)
					used = low_len();
				else
					used = min1(timing[REG_READ_LOW]) + min1(timing[REG_READ_SAMPLE]);
				return clamp_len(timing[REG_SLOT] > used ? timing[REG_SLOT] - used : 0);
			end
			ST_RECOV: return clamp_len(timing[REG_RECOVERY]);
			ST_GAP: return clamp_len(timing[REG_BYTE_GAP]);
			default: return 1;
		endcase
	endfunction

	// moves past the current segment, skipping empty ones; 1 when the operation ends
	function automatic bit leave_segment();
		seq_state_t cur;
		seq_state_t nxt;
		bit         bit_end;
		cur = seq_st;
		while (1) begin
			bit_end = 1'b0;
			nxt     = ST_IDLE;
			case (cur)
				ST_LOW: nxt = (seq_op == OP_WRITE) ? ST_REST : ST_WAIT;
				ST_WAIT: begin
					if (seq_op != OP_READ)
						return 1'b1;
					nxt = ST_REST;
				end
				ST_REST: begin
					if (seq_op == OP_WRITE) begin
						nxt = ST_RECOV;
					end else begin
						bit_end = 1'b1;
						nxt     = ST_LOW;
					end
				end
				ST_RECOV: begin
					bit_end = 1'b1;
					nxt     = ST_LOW;
				end
				ST_GAP: nxt = ST_LOW;
				default: return 1'b1;
			endcase
			if (bit_end) begin
				if (seq_op == OP_WRITE)
					seq_shift = seq_shift >> 1;
				if (seq_bit == 3'd7)
					return 1'b1;
				seq_bit = seq_bit + 3'd1;
			end
			seq_st    = nxt;
			seq_ticks = 0;
			if (seg_len(nxt) != 0)
				return 1'b0;
			cur = nxt;
		end
		return 1'b0;
	endfunction

	function automatic res_t master_tick(op_t op, logic [7:0] tx, logic line);
		res_t r;
		r = '0;
		if (seq_st == ST_IDLE && op != OP_NONE) begin
			seq_op    = op;
			seq_bit   = 3'd0;
			seq_shift = (op == OP_WRITE) ? tx : 8'd0;
			seq_pres  = 1'b0;
			seq_ticks = 0;
			seq_st    = (op == OP_READ) ? ST_GAP : ST_LOW;
			if (seg_len(seq_st) == 0)
				void'(leave_segment());
		end
		if (seq_st != ST_IDLE) begin
			r.busy_res  = 1'b1;
			r.drive_low = (seq_st == ST_LOW);
			if (seq_ticks + 1 >= seg_len(seq_st)) begin
				if (seq_st == ST_WAIT) begin
					if (seq_op == OP_RESET)
						seq_pres = ~line;
					else
						seq_shift = {line, seq_shift[7:1]};
				end
				if (leave_segment()) begin
					r.done_res = 1'b1;
					r.presence = (seq_op == OP_RESET) ? seq_pres : 1'b0;
					r.rx_byte  = (seq_op == OP_READ) ? seq_shift : 8'd0;
					seq_st     = ST_IDLE;
					seq_ticks  = 0;
				end
			end else begin
				seq_ticks = (seq_ticks + 1) & ((32'd1 << SEQ_CW) - 1);
			end
		end
		return r;
	endfunction

	// result side
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_if.ready <= ($urandom_range(99) >= sink_stall);
			@(posedge clk);
			if (arst_n && res_if.valid && res_if.ready)
				check_word();
		end
	end

	task automatic check_word();
		res_t got;
		res_t want;
		got = {res_if.drive_low, res_if.busy_res, res_if.done_res, res_if.presence,
			res_if.rx_byte};
		if (tick_outputs.size() == 0) begin
			n_bad++;
			if (n_bad <= 10)
				$display("unexpected word: drive_low=%b busy=%b done=%b presence=%b rx=%h",
					got.drive_low, got.busy_res, got.done_res, got.presence, got.rx_byte);
		end else begin
			want = tick_outputs.pop_front();
			if (got !== want) begin
				n_bad++;
				if (n_bad <= 10) begin
					$display("word mismatch at %0t: exp drive_low=%b busy=%b done=%b %s",
						$realtime, want.drive_low, want.busy_res, want.done_res,
						$sformatf("presence=%b rx=%h", want.presence, want.rx_byte));
					$display("  got drive_low=%b busy=%b done=%b presence=%b rx=%h",
						got.drive_low, got.busy_res, got.done_res, got.presence,
						got.rx_byte);
				end
			end
		end
	endtask

	// command side
	task automatic send_word(op_t op, logic [7:0] tx, logic line);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid   <= 1'b1;
		cmd_if.opcode  <= op;
		cmd_if.tx_byte <= tx;
		cmd_if.line_in <= line;
		do
			@(posedge clk);
		while (!cmd_if.ready);
		tick_outputs.push_back(master_tick(op, tx, line));
	endtask

	task automatic settle();
		@(negedge clk);
		cmd_if.valid <= 1'b0;
		while (tick_outputs.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_reg(reg_idx_t idx, int unsigned v);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= v[REG_W-1:0];
		timing[idx] = v & 32'h3FF;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_timing(int unsigned rst_low, int unsigned pres_wait, int unsigned one_low,
		int unsigned slot, int unsigned recov, int unsigned rd_low, int unsigned rd_sample,
		int unsigned gap);
		settle();
		set_reg(REG_RESET_LOW, rst_low);
		set_reg(REG_PRESENCE_WAIT, pres_wait);
		set_reg(REG_WRITE_ONE_LOW, one_low);
		set_reg(REG_SLOT, slot);
		set_reg(REG_RECOVERY, recov);
		set_reg(REG_READ_LOW, rd_low);
		set_reg(REG_READ_SAMPLE, rd_sample);
		set_reg(REG_BYTE_GAP, gap);
	endtask

	function automatic logic pick_line(line_mode_t mode);
		if (mode == LINE_LOW)
			return 1'b0;
		if (mode == LINE_HIGH)
			return 1'b1;
		return 1'($urandom_range(1));
	endfunction

	// one command, then ticks until the sequencer is idle again; busy ticks may carry
	// stray commands
	task automatic run_op(op_t op, logic [7:0] tx, line_mode_t mode, int unsigned noise_pct);
		send_word(op, tx, pick_line(mode));
		while (seq_st != ST_IDLE) begin
			if ($urandom_range(999) < drain_per_mille)
				settle();
			if ($urandom_range(99) < noise_pct)
				send_word(op_t'($urandom_range(3)), 8'($urandom), pick_line(mode));
			else
				send_word(OP_NONE, 8'($urandom), pick_line(mode));
		end
	endtask

	function automatic int unsigned rand_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 20)
			return 0;
		return $urandom_range(2, 1);
	endfunction

	task automatic test_default_timing();
		src_idle   = 0;
		sink_stall = 0;
		send_word(OP_NONE, 8'h00, 1'b1);
		send_word(OP_NONE, 8'hFF, 1'b0);
		// short slots and no gap keep the byte operations brief
		settle();
		set_reg(REG_SLOT, 2);
		set_reg(REG_BYTE_GAP, 0);
		run_op(OP_WRITE, 8'h81, LINE_RAND, 0);
		run_op(OP_READ, 8'h00, LINE_RAND, 0);
	endtask

	task automatic test_zero_timing();
		set_timing(0, 0, 0, 0, 0, 0, 0, 0);
		run_op(OP_RESET, 8'h00, LINE_LOW, 0);
		run_op(OP_WRITE, 8'hA5, LINE_RAND, 0);
		run_op(OP_READ, 8'h00, LINE_RAND, 0);
		set_timing(1, 1, 1, 1, 1, 1, 1, 1);
		run_op(OP_RESET, 8'h00, LINE_HIGH, 0);
		run_op(OP_WRITE, 8'h5A, LINE_RAND, 0);
		run_op(OP_READ, 8'h00, LINE_RAND, 0);
	endtask

	task automatic test_low_past_slot();
		set_timing(1, 1, 3, 2, 0, 3, 1, 0);
		run_op(OP_WRITE, 8'hF0, LINE_RAND, 0);
		run_op(OP_READ, 8'h00, LINE_RAND, 0);
	endtask

	task automatic test_busy_commands();
		set_timing(2, 2, 2, 3, 1, 1, 1, 1);
		drain_per_mille = 1000;
		run_op(OP_WRITE, 8'h3C, LINE_RAND, 100);
		drain_per_mille = 0;
		run_op(OP_READ, 8'hC3, LINE_RAND, 100);
		run_op(OP_RESET, 8'h81, LINE_RAND, 100);
	endtask

	task automatic test_random(int unsigned idle_pct, int unsigned stall_pct, int n_ops);
		src_idle        = idle_pct;
		sink_stall      = stall_pct;
		drain_per_mille = 4;
		for (int i = 0; i < n_ops; i++) begin
			set_timing(rand_len(), rand_len(), rand_len(), rand_len(), rand_len(),
				rand_len(), rand_len(), rand_len());
			repeat ($urandom_range(1))
				send_word(OP_NONE, 8'($urandom), 1'($urandom_range(1)));
			run_op(op_t'($urandom_range(3, 1)), 8'($urandom), LINE_RAND, 10);
		end
		drain_per_mille = 0;
	endtask

	initial begin
		cmd_if.valid    = 1'b0;
		cmd_if.opcode   = OP_NONE;
		cmd_if.tx_byte  = 8'd0;
		cmd_if.line_in  = 1'b1;
		cfg_we          = 1'b0;
		cfg_idx         = REG_RESET_LOW;
		cfg_data        = '0;
		arst_n          = 1'b0;
		src_idle        = 0;
		sink_stall      = 0;
		drain_per_mille = 0;
		n_bad           = 0;
		init_model();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_timing();
		test_zero_timing();
		test_low_past_slot();
		test_busy_commands();
		test_random(0, 0, 3);
		test_random(79, 0, 3);
		test_random(0, 79, 3);
		test_random(25, 25, 3);

		settle();
		repeat (4) @(posedge clk);
		if (n_bad == 0 && tick_outputs.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
